// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 25;
   localparam int CELL_W       = 16;
   localparam int CSR_IDX_W    = 1;

   localparam logic [7:0] NEWLINE_CODE      = 8'd10;
   localparam logic [7:0] SPACE_CODE        = 8'd32;
   localparam logic [7:0] DEFAULT_ATTR_RST  = 8'd1;
   localparam logic [7:0] CLEAR_ATTR_RST    = 8'd15;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_ATTR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_ATTR   = 1'd1;

   typedef enum logic [2:0] {
      CMD_WRITE      = 3'd0,
      CMD_WRITE_AT   = 3'd1,
      CMD_CLEAR      = 3'd2,
      CMD_READ       = 3'd3,
      CMD_SET_CURSOR = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic [7:0] default_attribute;
      logic [7:0] clear_attribute;
   } cfg_type;

endpackage

// ===== hw/rtl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console: character/attribute cell grid with a cursor, scroll and clear.
//
//   channel  handshake              beat
//   req      start & !busy          cmd, char_code, column, line, attribute
//   rsp      rsp_valid (one cycle)  cursor_column/line, scrolled, cell char/attr
//   csr      csr_valid & csr_ready  csr_index, csr_data
//
// Write, newline, set cursor: latch, then one cell write (newline, set cursor: none).
// Read: latch, issue the read, then capture the registered read port of the cell RAM.
// Clear: fills every cell with a space in the clear attribute, one cell write per cycle.
// Scroll: copies each row up one row, one copy per cycle, then zero-fills the last row.
// Reset clears cursor, state and rsp_valid and loads the config defaults; cell RAM holds no reset value.
// rsp is never stalled; csr_ready is always high.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_cmd,
   input  logic [7:0]                    req_char_code,
   input  logic [6:0]                    req_column,
   input  logic [4:0]                    req_line,
   input  logic [7:0]                    req_attribute,
   output logic                          rsp_valid,
   output logic [6:0]                    rsp_cursor_column,
   output logic [4:0]                    rsp_cursor_line,
   output logic                          rsp_scrolled,
   output logic [7:0]                    rsp_cell_char,
   output logic [7:0]                    rsp_cell_attribute,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import tcw_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);

   cfg_type           cfg_ff, cfg_in;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEFAULT_ATTR: cfg_in.default_attribute = csr_data;
            CSR_CLEAR_ATTR:   cfg_in.clear_attribute   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_attribute <= DEFAULT_ATTR_RST;
         cfg_ff.clear_attribute   <= CLEAR_ATTR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcw_ctrl #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_char_code      (req_char_code),
      .req_column         (req_column),
      .req_line           (req_line),
      .req_attribute      (req_attribute),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_line    (rsp_cursor_line),
      .rsp_scrolled       (rsp_scrolled),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attribute (rsp_cell_attribute),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data)
   );

   tcw_cell_ram #(
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== hw/rtl/tcw_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
   parameter  int DEPTH = 2000,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, cell addressing, scroll copy and fill sweeps,
// and the result beat.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
   parameter  int COLS  = tcw_pkg::COLS_DEFAULT,
   parameter  int ROWS  = tcw_pkg::ROWS_DEFAULT,
   localparam int CELLS = COLS * ROWS,
   localparam int AW    = $clog2(CELLS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tcw_pkg::cfg_type           cfg,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_cmd,
   input  logic [7:0]                 req_char_code,
   input  logic [6:0]                 req_column,
   input  logic [4:0]                 req_line,
   input  logic [7:0]                 req_attribute,
   output logic                       rsp_valid,
   output logic [6:0]                 rsp_cursor_column,
   output logic [4:0]                 rsp_cursor_line,
   output logic                       rsp_scrolled,
   output logic [7:0]                 rsp_cell_char,
   output logic [7:0]                 rsp_cell_attribute,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [tcw_pkg::CELL_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0] mem_rd_data
);
   import tcw_pkg::*;

   localparam int CW = $clog2(COLS);
   localparam int RW = $clog2(ROWS);

   state_type         state_ff, state_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [7:0]        char_ff, char_in;
   logic [7:0]        attr_ff, attr_in;
   logic [CW-1:0]     tcol_ff, tcol_in;
   logic [RW-1:0]     trow_ff, trow_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     wa_ff, wa_in;
   logic              wv_ff, wv_in;
   logic [CELL_W-1:0] fill_ff, fill_in;
   logic              scroll_ff, scroll_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic [4:0]        rsp_row_ff, rsp_row_in;
   logic              rsp_scr_ff, rsp_scr_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_attr_ff, rsp_attr_in;

   logic              accept;
   logic [CW-1:0]     col_sat;
   logic [RW-1:0]     row_sat;
   logic [AW-1:0]     pos;
   logic [7:0]        attr_eff;
   logic              is_nl;
   logic              col_last;
   logic              row_last;
   logic              respond;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   assign col_sat = (32'(req_column) >= COLS) ? CW'(COLS - 1) : CW'(req_column);
   assign row_sat = (32'(req_line) >= ROWS) ? RW'(ROWS - 1) : RW'(req_line);

   assign pos      = AW'(trow_ff) * AW'(COLS) + AW'(tcol_ff);
   assign attr_eff = (attr_ff == 8'd0) ? cfg.default_attribute : attr_ff;
   assign is_nl    = char_ff == NEWLINE_CODE;
   assign col_last = tcol_ff == CW'(COLS - 1);
   assign row_last = trow_ff == RW'(ROWS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      char_ff     <= char_in;
      attr_ff     <= attr_in;
      tcol_ff     <= tcol_in;
      trow_ff     <= trow_in;
      cnt_ff      <= cnt_in;
      wa_ff       <= wa_in;
      fill_ff     <= fill_in;
      scroll_ff   <= scroll_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      char_in     = char_ff;
      attr_in     = attr_ff;
      tcol_in     = tcol_ff;
      trow_in     = trow_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      cnt_in      = cnt_ff;
      wa_in       = wa_ff;
      wv_in       = 1'b0;
      fill_in     = fill_ff;
      scroll_in   = scroll_ff;
      respond     = 1'b0;
      rsp_scr_in  = 1'b0;
      rsp_char_in = 8'd0;
      rsp_attr_in = 8'd0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pos;
      mem_wr_data = {attr_eff, char_ff};
      mem_rd_en   = 1'b0;
      mem_rd_addr = pos;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_cmd;
               char_in = req_char_code;
               attr_in = req_attribute;
               if (req_cmd == CMD_WRITE) begin
                  tcol_in = col_ff;
                  trow_in = row_ff;
               end else begin
                  tcol_in = col_sat;
                  trow_in = row_sat;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_WRITE, CMD_WRITE_AT: begin
                  mem_wr_en = !is_nl;
                  if (is_nl || col_last) begin
                     col_in = '0;
                     if (row_last) begin
                        row_in    = trow_ff;
                        cnt_in    = AW'(COLS);
                        scroll_in = 1'b1;
                        state_in  = ST_SCROLL;
                     end else begin
                        row_in   = trow_ff + 1'b1;
                        respond  = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     col_in   = tcol_ff + 1'b1;
                     row_in   = trow_ff;
                     respond  = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               CMD_CLEAR: begin
                  col_in    = '0;
                  row_in    = '0;
                  cnt_in    = '0;
                  fill_in   = {cfg.clear_attribute, SPACE_CODE};
                  scroll_in = 1'b0;
                  state_in  = ST_FILL;
               end
               CMD_READ: begin
                  mem_rd_en = 1'b1;
                  state_in  = ST_READ;
               end
               CMD_SET_CURSOR: begin
                  col_in   = tcol_ff;
                  row_in   = trow_ff;
                  respond  = 1'b1;
                  state_in = ST_IDLE;
               end
               default: begin
                  respond  = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            respond     = 1'b1;
            rsp_char_in = mem_rd_data[7:0];
            rsp_attr_in = mem_rd_data[15:8];
            state_in    = ST_IDLE;
         end
         ST_SCROLL: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cnt_ff;
            wa_in       = cnt_ff - AW'(COLS);
            wv_in       = 1'b1;
            mem_wr_en   = wv_ff;
            mem_wr_addr = wa_ff;
            mem_wr_data = mem_rd_data;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cnt_in   = AW'(CELLS - COLS);
               fill_in  = '0;
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FILL: begin
            mem_wr_en = 1'b1;
            if (wv_ff) begin
               // last copy beat of the scroll still in flight
               mem_wr_addr = wa_ff;
               mem_wr_data = mem_rd_data;
            end else begin
               mem_wr_addr = cnt_ff;
               mem_wr_data = fill_ff;
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == AW'(CELLS - 1)) begin
                  respond    = 1'b1;
                  rsp_scr_in = scroll_ff;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = respond;
      rsp_col_in   = 7'(col_in);
      rsp_row_in   = 5'(row_in);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_column  = rsp_col_ff;
   assign rsp_cursor_line    = rsp_row_ff;
   assign rsp_scrolled       = rsp_scr_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attribute = rsp_attr_ff;

endmodule
